FILE: rtl/core/sflg_pkg.sv
package sflg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int SINE_SIZE = 1024;
  localparam int SINE_BITS = $clog2(SINE_SIZE);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index map
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN = 3'd4;

  // reset values of the registers
  localparam logic [19:0] DEPTH_RST = 20'd22579;
  localparam logic [31:0] PHASE_STEP_RST = 32'd24347;
  localparam logic signed [15:0] FB_GAIN_RST = 16'sd16384;
  localparam logic [14:0] DRY_GAIN_RST = 15'd16384;
  localparam logic [14:0] WET_GAIN_RST = 15'd16384;

  localparam logic signed [15:0] FB_LIMIT = 16'sd22937;
  localparam logic signed [15:0] OUT_SCALE = 16'sd26214;  // 0.8 in Q1.15

  // odd sine polynomial coefficients, Q30
  localparam logic [30:0] CA1 = 31'd1686629713;
  localparam logic [30:0] CA3 = 31'd693598669;
  localparam logic [30:0] CA5 = 31'd85569306;
  localparam logic [30:0] CA7 = 31'd5026995;
  localparam logic [30:0] CA9 = 31'd172272;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } sflg_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } sflg_out_t;

endpackage

FILE: rtl/core/sflg_ram.sv
module sflg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/stereo_flanger_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data   (left_in, right_in)
// out     | output    | out_valid / out_ready | out_data  (left_out, right_out)
// cfg     | input     | cfg_we                | cfg_idx, cfg_wdata
//
// A frame runs from idle through the phase fold, seven multiply/update steps
// of the shared 31x31 sine/delay multiplier, the delay RAM reads of the two
// taps, and the interpolate, wet, mix and scale states to the result register.
// Reset is synchronous; no clearing pass runs over the delay RAMs. Until the
// write pointer first wraps, entries above it read as zero.
// in_ready is high only in idle. A result waiting in the output register does
// not block a new request; a new result waits in its last step if the old one
// has not been taken.
module stereo_flanger_unit #(
  parameter int DELAY_DEPTH = sflg_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sflg_pkg::sflg_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sflg_pkg::sflg_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sflg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sflg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import sflg_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  // phase quantized to SINE_SIZE steps per turn
  localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_FOLD, S_MUL, S_ACC, S_RD_NEW, S_RD_OLD,
    S_INTERP, S_WET, S_MIX, S_SCALE, S_DONE
  } state_t;

  // which polynomial / delay product is in the shared multiplier
  typedef enum logic [2:0] {
    STP_SQ, STP_C7, STP_C5, STP_C3, STP_C1, STP_SIN, STP_DEPTH
  } step_t;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  state_t state_r;
  step_t  step_r;

  // configuration
  logic [19:0]       depth_r;
  logic [31:0]       phase_step_r;
  smp_t              fb_gain_r;
  logic [14:0]       dry_gain_r;
  logic [14:0]       wet_gain_r;

  // frame state
  smp_t              last_wet_r [2];
  logic [AW-1:0]     wp_r;
  logic              wrapped_r;
  logic [31:0]       phase_r;
  logic              out_valid_r;
  sflg_out_t         out_data_r;

  // datapath
  smp_t              in_smp_r [2];
  logic signed [31:0] fbp_r [2];
  logic [1:0]        quad_r;
  logic [30:0]       x_r;
  logic [30:0]       x2_r;
  logic [30:0]       t_r;
  logic [16:0]       u_r;
  logic [61:0]       prod_r;
  logic [11:0]       dint_r;
  logic [7:0]        frac_r;
  logic              newer_ok_r;
  logic              older_ok_r;
  smp_t              newer_r [2];
  logic signed [25:0] wacc_r [2];
  smp_t              wet_r [2];
  logic signed [31:0] mix_r [2];
  logic signed [47:0] oprod_r [2];

  // combinational
  logic              in_acc;
  logic [31:0]       p_nxt;
  logic [30:0]       mul_a;
  logic [30:0]       mul_b;
  logic [30:0]       coef;
  logic [31:0]       t_diff;
  logic [32:0]       s_rnd;
  logic [16:0]       mag_raw;
  logic [16:0]       mag;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     old_addr;
  logic [AW-1:0]     ram_raddr;
  logic              ram_we;
  smp_t              ram_rdata [2];
  smp_t              smp_nxt [2];
  smp_t              older_val [2];
  logic signed [25:0] wacc_nxt [2];
  smp_t              wet_nxt [2];
  logic signed [31:0] mix_nxt [2];
  logic signed [47:0] oprod_nxt [2];
  smp_t              out_nxt [2];
  logic [8:0]        w_new;
  logic signed [15:0] fb_clamped;
  logic signed [31:0] fb_rnd [2];

  function automatic smp_t sat_smp(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = (48'sd1 <<< (SAMPLE_W - 1)) - 48'sd1;
    lo = -(48'sd1 <<< (SAMPLE_W - 1));
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // feedback gain write, clamped to +/-0.7
  always_comb begin
    fb_clamped = $signed(cfg_wdata[15:0]);
    if (fb_clamped > FB_LIMIT) begin
      fb_clamped = FB_LIMIT;
    end else if (fb_clamped < -FB_LIMIT) begin
      fb_clamped = -FB_LIMIT;
    end
  end

  // shared multiplier operand select
  always_comb begin
    coef = CA9;
    case (step_r)
      STP_C7:  coef = CA7;
      STP_C5:  coef = CA5;
      STP_C3:  coef = CA3;
      STP_C1:  coef = CA1;
      default: coef = CA9;
    endcase
    mul_a = x2_r;
    mul_b = t_r;
    case (step_r)
      STP_SQ: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      STP_SIN: begin
        mul_a = x_r;
        mul_b = t_r;
      end
      STP_DEPTH: begin
        mul_a = 31'(depth_r);
        mul_b = 31'(u_r);
      end
      default: begin
        mul_a = x2_r;
        mul_b = t_r;
      end
    endcase
  end

  always_comb begin
    p_nxt   = phase_r & PH_MASK;
    t_diff  = {1'b0, coef} - prod_r[61:30];
    s_rnd   = {1'b0, prod_r[61:30]} + 33'd16384;
    mag_raw = s_rnd[31:15];
    mag     = (mag_raw > 17'd32768) ? 17'd32768 : mag_raw;
  end

  // delay taps: newest at wp, int(D) back, and the next older one
  assign rd_addr   = wp_r - AW'(dint_r);
  assign old_addr  = rd_addr - AW'(1);
  assign ram_raddr = (state_r == S_RD_OLD) ? old_addr : rd_addr;
  assign ram_we    = (state_r == S_FOLD);
  assign w_new     = 9'd256 - {1'b0, frac_r};

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      fb_rnd[c]    = (fbp_r[c] + 32'sd16384) >>> 15;
      smp_nxt[c]   = sat_smp(48'(in_smp_r[c]) + 48'(fb_rnd[c]));
      older_val[c] = older_ok_r ? ram_rdata[c] : '0;
      wacc_nxt[c]  = 26'(newer_r[c]) * 26'($signed({1'b0, w_new}))
                   + 26'(older_val[c]) * 26'($signed({1'b0, frac_r}));
      wet_nxt[c]   = 16'((wacc_r[c] + 26'sd128) >>> 8);
      mix_nxt[c]   = 32'($signed({1'b0, dry_gain_r})) * 32'(in_smp_r[c])
                   + 32'($signed({1'b0, wet_gain_r})) * 32'(wet_r[c]);
      oprod_nxt[c] = 48'(mix_r[c]) * 48'(OUT_SCALE);
      out_nxt[c]   = sat_smp((oprod_r[c] + (48'sd1 <<< 29)) >>> 30);
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_ch
    sflg_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (wp_r),
      .wdata (smp_nxt[c]),
      .raddr (ram_raddr),
      .rdata (ram_rdata[c])
    );
  end

  // control, frame state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      step_r        <= STP_SQ;
      out_valid_r   <= 1'b0;
      last_wet_r[0] <= '0;
      last_wet_r[1] <= '0;
      wp_r          <= '0;
      wrapped_r     <= 1'b0;
      phase_r       <= '0;
      depth_r       <= DEPTH_RST;
      phase_step_r  <= PHASE_STEP_RST;
      fb_gain_r     <= FB_GAIN_RST;
      dry_gain_r    <= DRY_GAIN_RST;
      wet_gain_r    <= WET_GAIN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DEPTH:      depth_r      <= cfg_wdata[19:0];
          CFG_PHASE_STEP: phase_step_r <= cfg_wdata[31:0];
          CFG_FB_GAIN:    fb_gain_r    <= fb_clamped;
          CFG_DRY_GAIN:   dry_gain_r   <= cfg_wdata[14:0];
          CFG_WET_GAIN:   wet_gain_r   <= cfg_wdata[14:0];
          default: ;
        endcase
      end

      // in the last step a taken result is replaced by the new one below
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          step_r  <= STP_SQ;
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          case (step_r)
            STP_SQ:  step_r <= STP_C7;
            STP_C7:  step_r <= STP_C5;
            STP_C5:  step_r <= STP_C3;
            STP_C3:  step_r <= STP_C1;
            STP_C1:  step_r <= STP_SIN;
            STP_SIN: step_r <= STP_DEPTH;
            default: step_r <= STP_SQ;
          endcase
          state_r <= (step_r == STP_DEPTH) ? S_RD_NEW : S_MUL;
        end
        S_RD_NEW: state_r <= S_RD_OLD;
        S_RD_OLD: state_r <= S_INTERP;
        S_INTERP: state_r <= S_WET;
        S_WET: begin
          last_wet_r[0] <= wet_nxt[0];
          last_wet_r[1] <= wet_nxt[1];
          state_r       <= S_MIX;
        end
        S_MIX:   state_r <= S_SCALE;
        S_SCALE: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.left_out  <= out_nxt[0];
            out_data_r.right_out <= out_nxt[1];
            wp_r                 <= wp_r + AW'(1);
            if (wp_r == AW'(DELAY_DEPTH - 1)) begin
              wrapped_r <= 1'b1;
            end
            phase_r <= phase_r + phase_step_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 62'(mul_a) * 62'(mul_b);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          in_smp_r[0] <= in_data.left_in;
          in_smp_r[1] <= in_data.right_in;
          fbp_r[0]    <= 32'(last_wet_r[0]) * 32'(fb_gain_r);
          fbp_r[1]    <= 32'(last_wet_r[1]) * 32'(fb_gain_r);
        end
      end
      S_FOLD: begin
        // quarter-wave fold of the quantized phase
        quad_r <= p_nxt[31:30];
        if (p_nxt[30]) begin
          x_r <= 31'h4000_0000 - {1'b0, p_nxt[29:0]};
        end else begin
          x_r <= {1'b0, p_nxt[29:0]};
        end
      end
      S_ACC: begin
        case (step_r)
          STP_SQ: begin
            x2_r <= prod_r[60:30];
            t_r  <= CA9;
          end
          STP_SIN: begin
            u_r <= quad_r[1] ? (17'd32768 - mag) : (17'd32768 + mag);
          end
          STP_DEPTH: begin
            dint_r <= prod_r[35:24];
            frac_r <= prod_r[23:16];
          end
          default: t_r <= t_diff[30:0];
        endcase
      end
      S_RD_NEW: begin
        newer_ok_r <= wrapped_r || (rd_addr <= wp_r);
      end
      S_RD_OLD: begin
        older_ok_r <= wrapped_r || (old_addr <= wp_r);
        newer_r[0] <= newer_ok_r ? ram_rdata[0] : '0;
        newer_r[1] <= newer_ok_r ? ram_rdata[1] : '0;
      end
      S_INTERP: begin
        wacc_r[0] <= wacc_nxt[0];
        wacc_r[1] <= wacc_nxt[1];
      end
      S_WET: begin
        wet_r[0] <= wet_nxt[0];
        wet_r[1] <= wet_nxt[1];
      end
      S_MIX: begin
        mix_r[0] <= mix_nxt[0];
        mix_r[1] <= mix_nxt[1];
      end
      S_SCALE: begin
        oprod_r[0] <= oprod_nxt[0];
        oprod_r[1] <= oprod_nxt[1];
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/sflg_checker.sv
module sflg_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sflg_pkg::sflg_out_t   out_data
);

  // one request in flight: ready drops right after an accept
  a_single_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted request");

  // no result can appear in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // a result never shows while the block is idle waiting for input
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready) || $past(out_valid))
    else $error("result raised without a request in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind stereo_flanger_unit sflg_checker u_sflg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
